[rtl/otuc_pkg.sv]
// Package for the opc.tcp URI checker: widths, status codes, character constants.
package otuc_pkg;

  localparam int unsigned MAX_URL_LENGTH_DEF = 4096;
  localparam int unsigned POS_W = 13;
  localparam int unsigned FLD_W = 12;
  localparam int unsigned PREFIX_LEN = 10;
  localparam int unsigned LEN_PAD = 4;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_LONG = 2'd2
  } check_status_t;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // "opc.tcp://"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      4'd0: c = 8'h6F;
      4'd1: c = 8'h70;
      4'd2: c = 8'h63;
      4'd3: c = 8'h2E;
      4'd4: c = 8'h74;
      4'd5: c = 8'h63;
      4'd6: c = 8'h70;
      4'd7: c = 8'h3A;
      4'd8: c = 8'h2F;
      4'd9: c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

endpackage

[rtl/opc_tcp_uri_checker.sv]
// Top level of the opc.tcp URI checker: byte-serial parse with a registered status output.
//
// Takes one URI byte per cycle on in_tdata, with in_tlast on the final byte, and
// returns one status transaction per URI when the final byte is taken. Every byte
// is handled in the cycle it is accepted by a small set of flags and 12/13-bit
// position counters; the status is held in an output register, so a new byte is
// accepted every cycle unless a finished status is still waiting on out_tready.
// The final byte is not parsed. Status ST_LONG is given when length + 4 exceeds
// MAX_URL_LENGTH; status ST_BAD covers a wrong prefix, a URI of ten bytes or
// less, a missing port digit, or a bad character.
module opc_tcp_uri_checker
  import otuc_pkg::*;
#(
  parameter int unsigned MAX_URL_LENGTH = MAX_URL_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] uri_char
  input  logic                  in_tlast,   // last_char
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [1:0] check_status, [13:2] host_length,
                                            // [25:14] port_start, [37:26] port_length, pad
);

  localparam logic [POS_W:0] MAX_LEN = (POS_W + 1)'(MAX_URL_LENGTH);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic prefix_ok_r, prefix_ok_nxt;
  logic in_port_r, in_port_nxt;
  logic port_seen_r, port_seen_nxt;
  logic name_seen_r, name_seen_nxt;
  logic invalid_r, invalid_nxt;
  logic in_brack_r, in_brack_nxt;
  logic [FLD_W-1:0] host_len_r, host_len_nxt;
  logic [FLD_W-1:0] port_start_r, port_start_nxt;
  logic [FLD_W-1:0] port_len_r, port_len_nxt;

  logic out_valid_r;
  check_status_t status_r, status_nxt;
  logic [FLD_W-1:0] o_hl_r, o_hl_nxt, o_ps_r, o_ps_nxt, o_pl_r, o_pl_nxt;

  logic in_acc;
  logic [7:0] c;
  logic [FLD_W-1:0] pos12;
  logic [POS_W:0] len;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc = in_tvalid && in_tready;
  assign c = in_tdata;
  assign pos12 = pos_r[FLD_W-1:0];
  assign len = {1'b0, pos_r} + (POS_W + 1)'(1);

  always_comb begin
    pos_nxt = pos_r;
    prefix_ok_nxt = prefix_ok_r;
    in_port_nxt = in_port_r;
    port_seen_nxt = port_seen_r;
    name_seen_nxt = name_seen_r;
    invalid_nxt = invalid_r;
    in_brack_nxt = in_brack_r;
    host_len_nxt = host_len_r;
    port_start_nxt = port_start_r;
    port_len_nxt = port_len_r;
    status_nxt = ST_BAD;
    o_hl_nxt = '0;
    o_ps_nxt = '0;
    o_pl_nxt = '0;

    if (in_tlast) begin
      if (len + (POS_W + 1)'(LEN_PAD) > MAX_LEN) begin
        status_nxt = ST_LONG;
      end else if (len <= (POS_W + 1)'(PREFIX_LEN) || !prefix_ok_r) begin
        status_nxt = ST_BAD;
      end else begin
        o_hl_nxt = host_len_r;
        o_ps_nxt = port_start_r;
        o_pl_nxt = port_len_r;
        if (port_seen_r && !invalid_r) begin
          status_nxt = ST_OK;
          if (port_len_r == '0) begin
            o_pl_nxt = pos12 + FLD_W'(1) - port_start_r;
          end
        end
      end
      // back to reset state for the next URI
      pos_nxt = '0;
      prefix_ok_nxt = 1'b1;
      in_port_nxt = 1'b0;
      port_seen_nxt = 1'b0;
      name_seen_nxt = 1'b0;
      invalid_nxt = 1'b0;
      in_brack_nxt = 1'b0;
      host_len_nxt = '0;
      port_start_nxt = '0;
      port_len_nxt = '0;
    end else begin
      if (pos_r < POS_W'(PREFIX_LEN)) begin
        if (fold_case(c) != prefix_char(pos_r[3:0])) begin
          prefix_ok_nxt = 1'b0;
        end
      end else if (prefix_ok_r) begin
        if (in_port_r) begin
          if (c >= CH_0 && c <= CH_9) begin
            if (!port_seen_r) begin
              port_seen_nxt = 1'b1;
              port_start_nxt = pos12;
            end
          end else if (c == CH_SLASH && !invalid_r) begin
            if (!port_seen_r) begin
              invalid_nxt = 1'b1;
            end else begin
              port_len_nxt = pos12 - port_start_r;
              name_seen_nxt = 1'b1;
            end
          end else if (!port_seen_r || !name_seen_r) begin
            invalid_nxt = 1'b1;
          end
        end else begin
          if (c == CH_COLON && !in_brack_r) begin
            host_len_nxt = pos12 - FLD_W'(PREFIX_LEN);
            in_port_nxt = 1'b1;
          end else if (c == CH_LBRACK) begin
            in_brack_nxt = 1'b1;
          end else if (c == CH_RBRACK) begin
            if (!in_brack_r) begin
              invalid_nxt = 1'b1;
            end else begin
              in_brack_nxt = 1'b0;
            end
          end
        end
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      prefix_ok_r <= 1'b1;
      in_port_r <= 1'b0;
      port_seen_r <= 1'b0;
      name_seen_r <= 1'b0;
      invalid_r <= 1'b0;
      in_brack_r <= 1'b0;
      host_len_r <= '0;
      port_start_r <= '0;
      port_len_r <= '0;
    end else if (in_acc) begin
      pos_r <= pos_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      in_port_r <= in_port_nxt;
      port_seen_r <= port_seen_nxt;
      name_seen_r <= name_seen_nxt;
      invalid_r <= invalid_nxt;
      in_brack_r <= in_brack_nxt;
      host_len_r <= host_len_nxt;
      port_start_r <= port_start_nxt;
      port_len_r <= port_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      status_r <= status_nxt;
      o_hl_r <= o_hl_nxt;
      o_ps_r <= o_ps_nxt;
      o_pl_r <= o_pl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, o_pl_r, o_ps_r, o_hl_r, status_r};

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_valid_r)
    else $error("final byte taken without a status");

  a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> pos_r == '0 && prefix_ok_r && !in_port_r)
    else $error("parser state not cleared after final byte");

  a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_LONG |-> o_hl_r == '0 && o_ps_r == '0 && o_pl_r == '0)
    else $error("too-long status with nonzero fields");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("input stalled with no pending status");

endmodule
